[sv/lpsp_pkg.sv]
package lpsp_pkg;

   // Epoch of J2000 in whole days.
   localparam logic [21:0] EPOCH_DAYS = 22'd2451545;

   // Mean angle rates in turns per day times 2^40, offsets in turns times 2^48.
   localparam logic [39:0] RATE_L =
      40'(((64'd4928237 << 40) + 64'd900000000) / 64'd1800000000);
   localparam logic [39:0] RATE_M =
      40'(((64'd9856003 << 40) + 64'd1800000000) / 64'd3600000000);
   localparam logic [47:0] OFF_L = 48'(((64'd14023 << 48) + 64'd9000) / 64'd18000);
   localparam logic [47:0] OFF_M = 48'(((64'd44691 << 48) + 64'd22500) / 64'd45000);

   // Equation of center coefficients in 2^-32 turn units.
   localparam logic [24:0] C1_TURN = 25'(((64'd383 << 32) + 64'd36000) / 64'd72000);
   localparam logic [17:0] C2_TURN = 18'(((64'd1 << 32) + 64'd9000) / 64'd18000);

   // Distance coefficients in Q30 astronomical units.
   localparam logic [30:0] D0_Q30 = 31'(((64'd100014 << 30) + 64'd50000) / 64'd100000);
   localparam logic [24:0] D1_Q30 = 25'(((64'd1671 << 30) + 64'd50000) / 64'd100000);
   localparam logic [17:0] D2_Q30 = 18'(((64'd14 << 30) + 64'd50000) / 64'd100000);

   // Obliquity at epoch in 2^-32 turns and its drift per day times 2^52.
   localparam logic [31:0] EPS0_TURN =
      32'(((64'd23439 << 32) + 64'd180000) / 64'd360000);
   localparam logic [22:0] EPS_RATE = 23'(((64'd1 << 52) + 64'd450000000) / 64'd900000000);

   // Astronomical unit in km times 16.
   localparam logic [31:0] AU_Q4 = 32'(((64'd1495978707 << 4) + 64'd5) / 64'd10);

   // Rotation unit constants.
   localparam int          CW       = 34;
   localparam int          STEPS    = 30;
   localparam logic [31:0] PI_Q30   = 32'd3373259426;
   localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

   localparam logic signed [CW-1:0] ATAN_TABLE [STEPS] = '{
      34'sh3243F6A8, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6, 34'sh03FEAB76,
      34'sh01FFD55B, 34'sh00FFFAAA, 34'sh007FFF55, 34'sh003FFFEA, 34'sh001FFFFD,
      34'sh000FFFFF, 34'sh0007FFFF, 34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF,
      34'sh00007FFF, 34'sh00003FFF, 34'sh00001FFF, 34'sh00000FFF, 34'sh000007FF,
      34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F, 34'sh0000003F,
      34'sh0000001F, 34'sh0000000F, 34'sh00000008, 34'sh00000004, 34'sh00000002
   };

   // Output range in whole kilometres.
   localparam int OUT_W = 29;
   localparam logic signed [33:0] OUT_LIMIT = 34'sd160000000;

   // Quadrant of an angle, from its top two bits.
   typedef enum logic [1:0] {
      QUAD_FIRST  = 2'd0,
      QUAD_SECOND = 2'd1,
      QUAD_THIRD  = 2'd2,
      QUAD_FOURTH = 2'd3
   } quad_type;

endpackage

[sv/lpsp_cordic.sv]
module lpsp_cordic #(
   parameter int SIDE_W = 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic [31:0]                    angle,
   input  logic [SIDE_W-1:0]              side_in,
   output logic signed [lpsp_pkg::CW-1:0] sin_out,
   output logic signed [lpsp_pkg::CW-1:0] cos_out,
   output logic [SIDE_W-1:0]              side_out
);

   localparam int CW = lpsp_pkg::CW;
   localparam int N  = lpsp_pkg::STEPS;

   logic signed [CW-1:0] x_ff [N+1];
   logic signed [CW-1:0] y_ff [N+1];
   logic signed [CW-1:0] z_ff [N+1];
   logic signed [CW-1:0] x_in [N+1];
   logic signed [CW-1:0] y_in [N+1];
   logic signed [CW-1:0] z_in [N+1];
   lpsp_pkg::quad_type   quad_ff [N+1];
   logic [SIDE_W-1:0]    side_ff [N+1];
   logic [61:0]          zprod;
   logic signed [CW-1:0] sin_ff, cos_ff, sin_in, cos_in;

   // Scale the angle within its quadrant to Q30 radians.
   assign zprod   = angle[29:0] * lpsp_pkg::PI_Q30;
   assign x_in[0] = lpsp_pkg::GAIN_Q30;
   assign y_in[0] = '0;
   assign z_in[0] = CW'(zprod[61:31]);

   // One rotation step per stage.
   for (genvar i = 0; i < N; i++) begin : g_step
      assign x_in[i+1] = z_ff[i][CW-1] ? x_ff[i] + (y_ff[i] >>> i) : x_ff[i] - (y_ff[i] >>> i);
      assign y_in[i+1] = z_ff[i][CW-1] ? y_ff[i] - (x_ff[i] >>> i) : y_ff[i] + (x_ff[i] >>> i);
      assign z_in[i+1] = z_ff[i][CW-1] ? z_ff[i] + lpsp_pkg::ATAN_TABLE[i]
                                       : z_ff[i] - lpsp_pkg::ATAN_TABLE[i];
   end

   // Fold the first-quadrant result back into the quadrant of the angle.
   always_comb begin
      case (quad_ff[N])
         lpsp_pkg::QUAD_FIRST: begin
            sin_in = y_ff[N];
            cos_in = x_ff[N];
         end
         lpsp_pkg::QUAD_SECOND: begin
            sin_in = x_ff[N];
            cos_in = -y_ff[N];
         end
         lpsp_pkg::QUAD_THIRD: begin
            sin_in = -y_ff[N];
            cos_in = -x_ff[N];
         end
         default: begin
            sin_in = -x_ff[N];
            cos_in = y_ff[N];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= N; k++) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
            z_ff[k] <= z_in[k];
         end
         quad_ff[0] <= lpsp_pkg::quad_type'(angle[31:30]);
         for (int k = 1; k <= N; k++) begin
            quad_ff[k] <= quad_ff[k-1];
         end
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   // The side word carries valid bits, so it is cleared on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= N; k++) begin
            side_ff[k] <= '0;
         end
         side_out <= '0;
      end else if (en) begin
         side_ff[0] <= side_in;
         for (int k = 1; k <= N; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         side_out <= side_ff[N];
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

[sv/lpsp_front.sv]
module lpsp_front #(
   parameter int DAY_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [37:0] julian_date,
   output logic        out_valid,
   output logic [31:0] lm,
   output logic [31:0] ma,
   output logic [31:0] eps
);

   localparam int F  = DAY_FRAC_BITS;
   localparam int NW = ((22 + F > 38) ? 22 + F : 38) + 1;
   localparam int MW = 40 + F;
   localparam int HM = (MW + 1) / 2;
   localparam int DH = (NW + 1) / 2;

   logic                    v1_ff, v2_ff, v3_ff;
   logic signed [NW-1:0]    n_ff, n_in;
   logic [MW-1:0]           nm;
   logic [HM+19:0]          l_ll_ff, l_ll_in, l_hl_ff, l_hl_in;
   logic [MW-HM+19:0]       l_lh_ff, l_lh_in, l_hh_ff, l_hh_in;
   logic [HM+19:0]          m_ll_ff, m_ll_in, m_hl_ff, m_hl_in;
   logic [MW-HM+19:0]       m_lh_ff, m_lh_in, m_hh_ff, m_hh_in;
   logic [DH+22:0]          d_lo_ff, d_lo_in;
   logic signed [NW-DH+23:0] d_hi_ff, d_hi_in;
   logic [MW-1:0]           lp, mp;
   logic [63:0]             lsum, msum;
   logic signed [79:0]      dsum, dsh;
   logic [31:0]             lm_ff, ma_ff, eps_ff, lm_in, ma_in, eps_in;

   // Day count from the epoch.
   assign n_in = $signed(NW'(julian_date)) - $signed(NW'(lpsp_pkg::EPOCH_DAYS) << F);

   // Partial products of the rate products and the obliquity drift.
   assign nm      = MW'(n_ff);
   assign l_ll_in = lpsp_pkg::RATE_L[19:0]  * nm[HM-1:0];
   assign l_lh_in = lpsp_pkg::RATE_L[19:0]  * nm[MW-1:HM];
   assign l_hl_in = lpsp_pkg::RATE_L[39:20] * nm[HM-1:0];
   assign l_hh_in = lpsp_pkg::RATE_L[39:20] * nm[MW-1:HM];
   assign m_ll_in = lpsp_pkg::RATE_M[19:0]  * nm[HM-1:0];
   assign m_lh_in = lpsp_pkg::RATE_M[19:0]  * nm[MW-1:HM];
   assign m_hl_in = lpsp_pkg::RATE_M[39:20] * nm[HM-1:0];
   assign m_hh_in = lpsp_pkg::RATE_M[39:20] * nm[MW-1:HM];
   assign d_lo_in = n_ff[DH-1:0] * lpsp_pkg::EPS_RATE;
   assign d_hi_in = $signed(n_ff[NW-1:DH]) * $signed({1'b0, lpsp_pkg::EPS_RATE});

   // Sum the partials; the top 32 bits of each aligned sum are the angle in turns.
   assign lp = MW'(l_ll_ff) + (MW'(l_lh_ff) << HM) + (MW'(l_hl_ff) << 20)
             + (MW'(l_hh_ff) << (20 + HM));
   assign mp = MW'(m_ll_ff) + (MW'(m_lh_ff) << HM) + (MW'(m_hl_ff) << 20)
             + (MW'(m_hh_ff) << (20 + HM));
   assign lsum  = (64'(lp) << (24 - F)) + (64'(lpsp_pkg::OFF_L) << 16);
   assign msum  = (64'(mp) << (24 - F)) + (64'(lpsp_pkg::OFF_M) << 16);
   assign lm_in = lsum[63:32];
   assign ma_in = msum[63:32];

   // Rounded obliquity drift, wrapped to one turn.
   assign dsum   = (80'(d_hi_ff) <<< DH) + $signed(80'(d_lo_ff)) + (80'sd1 <<< (19 + F));
   assign dsh    = dsum >>> (20 + F);
   assign eps_in = lpsp_pkg::EPS0_TURN - dsh[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff    <= n_in;
         l_ll_ff <= l_ll_in;
         l_lh_ff <= l_lh_in;
         l_hl_ff <= l_hl_in;
         l_hh_ff <= l_hh_in;
         m_ll_ff <= m_ll_in;
         m_lh_ff <= m_lh_in;
         m_hl_ff <= m_hl_in;
         m_hh_ff <= m_hh_in;
         d_lo_ff <= d_lo_in;
         d_hi_ff <= d_hi_in;
         lm_ff   <= lm_in;
         ma_ff   <= ma_in;
         eps_ff  <= eps_in;
      end
   end

   assign out_valid = v3_ff;
   assign lm        = lm_ff;
   assign ma        = ma_ff;
   assign eps       = eps_ff;

endmodule

[sv/low_precision_sun_position.sv]
// Low-precision sun position: each Julian date transaction yields one transaction
// with the equatorial x, y, z sun position in whole kilometres. The block takes one
// date per cycle while req_stall is low; its pipeline has two 32-stage rotation
// units in series (one for the mean anomaly and its double, one for the ecliptic
// longitude and the obliquity) plus eleven stages of day count, multiply and round
// steps. A result that is not taken waits in the output register and one more in a
// skid register; req_stall rises only once both hold a result.
module low_precision_sun_position #(
   parameter int DAY_FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [37:0]         req_julian_date,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [28:0]  rsp_sun_x_km,
   output logic signed [28:0]  rsp_sun_y_km,
   output logic signed [28:0]  rsp_sun_z_km
);

   localparam int CW = lpsp_pkg::CW;

   logic                 en;
   logic                 v3;
   logic [31:0]          lm3, ma3, eps3;
   logic signed [CW-1:0] s1, c1, s2, c2, sl, cl, se, ce;
   logic [0:0]           va;
   logic [63:0]          side_a;
   logic [0:0]           vb;
   logic [CW-1:0]        side_b;

   logic                 v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff, v10_ff;
   logic signed [63:0]   pc1_ff, pc2_ff, pd1_ff, pd2_ff;
   logic signed [63:0]   pc1_in, pc2_in, pd1_in, pd2_in;
   logic [31:0]          lm4_ff, eps4_ff;
   logic [31:0]          lam5_ff, eps5_ff, lam5_in;
   logic signed [31:0]   d5_ff, d5_in;
   logic signed [63:0]   censum, cen, rd1, rd2;
   logic signed [63:0]   radp6_ff, radp6_in, radr;
   logic [31:0]          lam6_ff, eps6_ff, lam7_ff, eps7_ff;
   logic signed [CW-1:0] rad7_ff, rad7_in, radb;
   logic signed [67:0]   xp8_ff, rcep8_ff, rsep8_ff, xp8_in, rcep8_in, rsep8_in;
   logic signed [CW-1:0] sl8_ff, sl9_ff, rce9_ff, rse9_ff, rce9_in, rse9_in;
   logic signed [67:0]   xp9_ff, xp10_ff, yp10_ff, zp10_ff, yp10_in, zp10_in;
   logic signed [67:0]   rce_r, rse_r;

   logic                 rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;
   logic signed [28:0]   rx_ff, ry_ff, rz_ff, rx_in, ry_in, rz_in;
   logic signed [28:0]   sx_ff, sy_ff, sz_ff, sx_in, sy_in, sz_in;
   logic signed [28:0]   nx, ny, nz;
   logic                 push, take;

   // Round a product right by 34 bits and clamp it to the output range.
   function automatic logic signed [28:0] round_sat(input logic signed [67:0] v);
      logic signed [67:0] t;
      logic signed [33:0] r;
      t = (v + (68'sd1 <<< 33)) >>> 34;
      r = t[33:0];
      if (r > lpsp_pkg::OUT_LIMIT) begin
         r = lpsp_pkg::OUT_LIMIT;
      end else if (r < -lpsp_pkg::OUT_LIMIT) begin
         r = -lpsp_pkg::OUT_LIMIT;
      end
      return r[28:0];
   endfunction

   // The pipeline moves whenever the skid register is free.
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   lpsp_front #(.DAY_FRAC_BITS(DAY_FRAC_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_valid),
      .julian_date (req_julian_date),
      .out_valid   (v3),
      .lm          (lm3),
      .ma          (ma3),
      .eps         (eps3)
   );

   // Sine and cosine of the mean anomaly and of its double.
   lpsp_cordic #(.SIDE_W(1)) u_rot_m1 (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .angle    (ma3),
      .side_in  (v3),
      .sin_out  (s1),
      .cos_out  (c1),
      .side_out (va)
   );

   lpsp_cordic #(.SIDE_W(64)) u_rot_m2 (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .angle    ({ma3[30:0], 1'b0}),
      .side_in  ({lm3, eps3}),
      .sin_out  (s2),
      .cos_out  (c2),
      .side_out (side_a)
   );

   // Harmonic products for the center term and the distance.
   assign pc1_in = $signed({1'b0, lpsp_pkg::C1_TURN}) * s1;
   assign pc2_in = $signed({1'b0, lpsp_pkg::C2_TURN}) * s2;
   assign pd1_in = $signed({1'b0, lpsp_pkg::D1_Q30}) * c1;
   assign pd2_in = $signed({1'b0, lpsp_pkg::D2_Q30}) * c2;

   // Ecliptic longitude in 2^-32 turns and distance in Q30 astronomical units.
   assign censum  = pc1_ff + pc2_ff;
   assign cen     = (censum + (64'sd1 <<< 29)) >>> 30;
   assign lam5_in = lm4_ff + cen[31:0];
   assign rd1     = (pd1_ff + (64'sd1 <<< 29)) >>> 30;
   assign rd2     = (pd2_ff + (64'sd1 <<< 29)) >>> 30;
   assign d5_in   = 32'($signed({1'b0, lpsp_pkg::D0_Q30})) - rd1[31:0] - rd2[31:0];

   // Radius in km times 16.
   assign radp6_in = d5_ff * $signed({1'b0, lpsp_pkg::AU_Q4});
   assign radr     = (radp6_ff + (64'sd1 <<< 29)) >>> 30;
   assign rad7_in  = radr[CW-1:0];

   // Sine and cosine of the ecliptic longitude and of the obliquity.
   lpsp_cordic #(.SIDE_W(1)) u_rot_lam (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .angle    (lam7_ff),
      .side_in  (v7_ff),
      .sin_out  (sl),
      .cos_out  (cl),
      .side_out (vb)
   );

   lpsp_cordic #(.SIDE_W(CW)) u_rot_eps (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .angle    (eps7_ff),
      .side_in  (rad7_ff),
      .sin_out  (se),
      .cos_out  (ce),
      .side_out (side_b)
   );

   // Coordinate products.
   assign radb     = $signed(side_b);
   assign xp8_in   = radb * cl;
   assign rcep8_in = radb * ce;
   assign rsep8_in = radb * se;
   assign rce_r    = (rcep8_ff + (68'sd1 <<< 29)) >>> 30;
   assign rse_r    = (rsep8_ff + (68'sd1 <<< 29)) >>> 30;
   assign rce9_in  = rce_r[CW-1:0];
   assign rse9_in  = rse_r[CW-1:0];
   assign yp10_in  = rce9_ff * sl9_ff;
   assign zp10_in  = rse9_ff * sl9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
      end else if (en) begin
         v4_ff  <= va[0];
         v5_ff  <= v4_ff;
         v6_ff  <= v5_ff;
         v7_ff  <= v6_ff;
         v8_ff  <= vb[0];
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pc1_ff   <= pc1_in;
         pc2_ff   <= pc2_in;
         pd1_ff   <= pd1_in;
         pd2_ff   <= pd2_in;
         lm4_ff   <= side_a[63:32];
         eps4_ff  <= side_a[31:0];
         lam5_ff  <= lam5_in;
         eps5_ff  <= eps4_ff;
         d5_ff    <= d5_in;
         radp6_ff <= radp6_in;
         lam6_ff  <= lam5_ff;
         eps6_ff  <= eps5_ff;
         rad7_ff  <= rad7_in;
         lam7_ff  <= lam6_ff;
         eps7_ff  <= eps6_ff;
         xp8_ff   <= xp8_in;
         rcep8_ff <= rcep8_in;
         rsep8_ff <= rsep8_in;
         sl8_ff   <= sl;
         xp9_ff   <= xp8_ff;
         rce9_ff  <= rce9_in;
         rse9_ff  <= rse9_in;
         sl9_ff   <= sl8_ff;
         xp10_ff  <= xp9_ff;
         yp10_ff  <= yp10_in;
         zp10_ff  <= zp10_in;
      end
   end

   // Output register with one skid entry behind it.
   assign nx   = round_sat(xp10_ff);
   assign ny   = round_sat(yp10_ff);
   assign nz   = round_sat(zp10_ff);
   assign push = en && v10_ff;
   assign take = rsp_valid_ff && !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rx_in = rx_ff;
      ry_in = ry_ff;
      rz_in = rz_ff;
      sx_in = sx_ff;
      sy_in = sy_ff;
      sz_in = sz_ff;
      if (skid_valid_ff) begin
         if (take) begin
            rx_in = sx_ff;
            ry_in = sy_ff;
            rz_in = sz_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!rsp_valid_ff || take) begin
            rx_in = nx;
            ry_in = ny;
            rz_in = nz;
            rsp_valid_in = 1'b1;
         end else begin
            sx_in = nx;
            sy_in = ny;
            sz_in = nz;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      rz_ff <= rz_in;
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      sz_ff <= sz_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sun_x_km = rx_ff;
   assign rsp_sun_y_km = ry_ff;
   assign rsp_sun_z_km = rz_ff;

endmodule

[sv/lpsp_checker.sv]
module lpsp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [28:0] rsp_sun_x_km,
   input logic signed [28:0] rsp_sun_y_km,
   input logic signed [28:0] rsp_sun_z_km
);

   // The input side is held back only while a result is waiting.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result waiting");

   // Reset leaves no result on the output.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present right after reset");

   // Every coordinate stays inside the saturation range.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sun_x_km <= 29'sd160000000 && rsp_sun_x_km >= -29'sd160000000
                  && rsp_sun_y_km <= 29'sd160000000 && rsp_sun_y_km >= -29'sd160000000
                  && rsp_sun_z_km <= 29'sd160000000 && rsp_sun_z_km >= -29'sd160000000))
      else $error("coordinate out of range");

   // A stalled result transaction holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sun_x_km)
                                 && $stable(rsp_sun_y_km) && $stable(rsp_sun_z_km))
      else $error("stalled result changed");

endmodule

bind low_precision_sun_position lpsp_checker u_lpsp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_sun_x_km (rsp_sun_x_km),
   .rsp_sun_y_km (rsp_sun_y_km),
   .rsp_sun_z_km (rsp_sun_z_km)
);

[verif/tb_low_precision_sun_position.sv]
module tb_low_precision_sun_position;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 16;
   localparam int STALL_LIMIT = 4000;
   localparam longint unsigned JD_MAX = (64'd1 << 38) - 1;
   localparam longint unsigned EPOCH_JD = 64'(lpsp_pkg::EPOCH_DAYS) << FRAC;

   typedef struct {
      logic signed [28:0] x;
      logic signed [28:0] y;
      logic signed [28:0] z;
   } position_type;

   // Keeps the predicted sun positions in order and checks each result transaction.
   class position_board;
      position_type pending[$];
      int           mismatches;

      function longint rnd(longint v, int s);
         return (v + (64'sd1 <<< (s - 1))) >>> s;
      endfunction

      function void rotate(logic [31:0] ang, output longint sn, output longint cs);
         longint x, y, z, dx, dy;
         logic [63:0] rem;
         lpsp_pkg::quad_type q;
         q = lpsp_pkg::quad_type'(ang[31:30]);
         rem = {34'd0, ang[29:0]};
         z = longint'((rem * 64'(lpsp_pkg::PI_Q30)) >> 31);
         x = longint'(lpsp_pkg::GAIN_Q30);
         y = 0;
         for (int i = 0; i < lpsp_pkg::STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= longint'(lpsp_pkg::ATAN_TABLE[i]);
            end else begin
               x += dx; y -= dy; z += longint'(lpsp_pkg::ATAN_TABLE[i]);
            end
         end
         case (q)
            lpsp_pkg::QUAD_FIRST: begin sn = y; cs = x; end
            lpsp_pkg::QUAD_SECOND: begin sn = x; cs = -y; end
            lpsp_pkg::QUAD_THIRD: begin sn = -y; cs = -x; end
            default: begin sn = -x; cs = y; end
         endcase
      endfunction

      function logic [31:0] mean_turns(logic [63:0] n_u, logic [63:0] rate, logic [63:0] off);
         logic [63:0] p;
         p = (rate * n_u) << (24 - FRAC);
         return 32'((p + (off << 16)) >> 32);
      endfunction

      function logic signed [28:0] clamp_km(longint v);
         if (v > 160000000) v = 160000000;
         if (v < -160000000) v = -160000000;
         return 29'(v);
      endfunction

      function position_type sun_position(logic [37:0] jd);
         longint n, s1, c1, s2, c2, sl, cl, se, ce, centre, d, radius, rce, drift;
         logic [31:0] lm, ma, lam, eps;
         position_type r;
         n = longint'({26'd0, jd}) - longint'(EPOCH_JD);
         lm = mean_turns(64'(n), 64'(lpsp_pkg::RATE_L), 64'(lpsp_pkg::OFF_L));
         ma = mean_turns(64'(n), 64'(lpsp_pkg::RATE_M), 64'(lpsp_pkg::OFF_M));
         rotate(ma, s1, c1);
         rotate(ma << 1, s2, c2);
         centre = rnd(longint'(lpsp_pkg::C1_TURN) * s1 + longint'(lpsp_pkg::C2_TURN) * s2,
                      30);
         lam = 32'(64'(lm) + 64'(centre));
         d = longint'(lpsp_pkg::D0_Q30) - rnd(longint'(lpsp_pkg::D1_Q30) * c1, 30)
             - rnd(longint'(lpsp_pkg::D2_Q30) * c2, 30);
         radius = rnd(d * longint'(lpsp_pkg::AU_Q4), 30);
         drift = rnd(n * longint'(lpsp_pkg::EPS_RATE), 20 + FRAC);
         eps = 32'(64'(lpsp_pkg::EPS0_TURN) - 64'(drift));
         rotate(lam, sl, cl);
         rotate(eps, se, ce);
         rce = rnd(radius * ce, 30);
         r.x = clamp_km(rnd(radius * cl, 34));
         r.y = clamp_km(rnd(rce * sl, 34));
         r.z = clamp_km(rnd(rnd(radius * se, 30) * sl, 34));
         return r;
      endfunction

      function void note_date(logic [37:0] jd);
         pending.push_back(sun_position(jd));
      endfunction

      function void check_position(position_type got);
         position_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result transaction: x=%0d y=%0d z=%0d",
                        got.x, got.y, got.z);
            return;
         end
         want = pending.pop_front();
         if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Position mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                        want.x, want.y, want.z, got.x, got.y, got.z);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic [37:0] req_julian_date = '0;
   logic rsp_stall = 0;
   logic req_stall, rsp_valid;
   logic signed [28:0] rsp_sun_x_km, rsp_sun_y_km, rsp_sun_z_km;

   position_board board = new();
   bit   burst_mode = 0;
   int   quiet_cycles = 0;

   low_precision_sun_position #(.DAY_FRAC_BITS(FRAC)) dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // Record accepted transactions on both channels.
   always @(posedge clock) begin
      position_type got;
      if (!reset && req_valid && !req_stall) board.note_date(req_julian_date);
      if (!reset && rsp_valid && !rsp_stall) begin
         got.x = rsp_sun_x_km;
         got.y = rsp_sun_y_km;
         got.z = rsp_sun_z_km;
         board.check_position(got);
      end
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_date(logic [37:0] jd);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 14);
      repeat (gap) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_julian_date <= jd;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [37:0] random_date();
      logic [63:0] v;
      int pick;
      pick = $urandom_range(0, 9);
      v = {$urandom, $urandom};
      if (pick < 6)
         // Dates within a few centuries of the epoch.
         return 38'(EPOCH_JD + 64'(longint'($urandom_range(0, 200000)) - 100000) * 65536
                    + (v & 64'hFFFF));
      else
         return 38'(v);
   endfunction

   // Result side stalls a random number of cycles before each transaction.
   initial begin
      int k;
      @(negedge reset);
      forever begin
         k = burst_mode ? 0 : $urandom_range(0, 14);
         if (k > 0) begin
            rsp_stall <= 1;
            repeat (k) @(posedge clock);
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      logic [37:0] directed[$];
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Extremes of the date, the epoch itself and far dates that wrap the angles.
      directed = '{38'd0, 38'(JD_MAX), 38'(EPOCH_JD), 38'(EPOCH_JD - 1), 38'(EPOCH_JD + 1),
                   38'(EPOCH_JD + 64'd32768), 38'(EPOCH_JD + 64'd91 * 65536),
                   38'(EPOCH_JD + 64'd182 * 65536), 38'(EPOCH_JD + 64'd273 * 65536),
                   38'h2AAAAAAAAA, 38'h1555555555, 38'(64'd1 << 37),
                   38'(EPOCH_JD + 64'd36525 * 65536 * 30), 38'(64'hFFFF)};
      foreach (directed[i]) send_date(directed[i]);

      for (int i = 0; i < 950; i++) begin
         if (i % 100 == 0) burst_mode = ($urandom_range(0, 3) == 0);
         send_date(random_date());
      end
      req_valid <= 0;
      burst_mode = 0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
